[rtl/core/i2crte_pkg.sv]
// Package for the I2C register transfer engine.
// Holds sizes, request and phase codes, and the structs passed between modules.
// No dependencies.
`timescale 1ns / 1ps

package i2crte_pkg;

  localparam int TX_DEPTH         = 16;
  localparam int TARGET_MEM_BYTES = 256;
  localparam int TX_IDX_W         = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam int MEM_ADDR_W       = $clog2(TARGET_MEM_BYTES);
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_ROLE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REG_SIZE = 2'd2;

  typedef enum logic [2:0] {
    REQ_LOAD     = 3'd0,
    REQ_START_WR = 3'd1,
    REQ_START_RD = 3'd2,
    REQ_TX_READY = 3'd3,
    REQ_RX_BYTE  = 3'd4,
    REQ_STOP     = 3'd5,
    REQ_HOST     = 3'd6,
    REQ_NONE     = 3'd7
  } req_e_t;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_SEND_REG   = 3'd1,
    PH_READ_START = 3'd2,
    PH_READ       = 3'd3,
    PH_TRANSMIT   = 3'd4,
    PH_SELECT     = 3'd5,
    PH_DATA       = 3'd6
  } phase_t;

  typedef struct packed {
    logic       start_cond;
    logic       read_dir;
    logic [6:0] target_address;
    logic       stop_cond;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic [7:0] rx_index;
    logic       done_res;
    logic       tx_from_mem;
    logic       rx_from_mem;
  } res_t;

  typedef struct packed {
    logic                  rd_en;
    logic                  wr_en;
    logic [MEM_ADDR_W-1:0] addr;
    logic [7:0]            wr_data;
  } mem_req_t;

endpackage

[rtl/core/i2crte_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module i2crte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/i2crte_seq.sv]
// Transfer sequencer: configuration registers, phase machine, counters and tx buffer.
// Produces the result fields and the target memory request for each item.
// Depends on i2crte_pkg.
`timescale 1ns / 1ps

module i2crte_seq (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [i2crte_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [i2crte_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            accept,
  input  logic [2:0]                      req_type,
  input  logic [6:0]                      dev_addr,
  input  logic [7:0]                      reg_addr,
  input  logic [7:0]                      count,
  input  logic [7:0]                      data_byte,
  input  logic [7:0]                      mem_index,
  input  logic                            host_write,
  output i2crte_pkg::res_t                res,
  output i2crte_pkg::mem_req_t            mem
);

  i2crte_pkg::phase_t phase, phase_next;
  logic       role, role_next;
  logic [7:0] reg_size, reg_size_next;
  logic [7:0] byte_pointer, byte_pointer_next;
  logic [7:0] send_left, send_left_next;
  logic [7:0] receive_left, receive_left_next;
  logic [7:0] selected_register, selected_register_next;
  logic [7:0] read_position, read_position_next;
  logic [6:0] peer_address, peer_address_next;
  logic [7:0] tx_store [i2crte_pkg::TX_DEPTH];
  logic       tx_we;

  i2crte_pkg::req_e_t req;
  logic [15:0] sel_prod;
  logic [7:0]  send_dec;
  logic [7:0]  recv_dec;
  logic [7:0]  read_left;
  logic [7:0]  clamp_cnt;

  assign req       = i2crte_pkg::req_e_t'(req_type);
  assign sel_prod  = reg_size * data_byte;
  assign send_dec  = send_left - 8'd1;
  assign recv_dec  = receive_left - 8'd1;
  assign read_left = (receive_left != 8'd0) ? recv_dec : receive_left;
  assign clamp_cnt = ({1'b0, count} > 9'(i2crte_pkg::TX_DEPTH))
                     ? 8'(i2crte_pkg::TX_DEPTH) : count;

  // next state
  always_comb begin
    phase_next             = phase;
    role_next              = role;
    reg_size_next          = reg_size;
    byte_pointer_next      = byte_pointer;
    send_left_next         = send_left;
    receive_left_next      = receive_left;
    selected_register_next = selected_register;
    read_position_next     = read_position;
    peer_address_next      = peer_address;
    tx_we                  = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        i2crte_pkg::CFG_ROLE: begin
          role_next  = cfg_data[0];
          phase_next = cfg_data[0] ? i2crte_pkg::PH_SELECT : i2crte_pkg::PH_IDLE;
        end
        i2crte_pkg::CFG_REG_SIZE: begin
          reg_size_next = cfg_data;
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      unique case (req)
        i2crte_pkg::REQ_LOAD: begin
          tx_we = ({1'b0, mem_index} < 9'(i2crte_pkg::TX_DEPTH));
        end
        i2crte_pkg::REQ_START_WR, i2crte_pkg::REQ_START_RD: begin
          if (!role) begin
            peer_address_next      = dev_addr;
            selected_register_next = reg_addr;
            byte_pointer_next      = 8'd0;
            read_position_next     = 8'd0;
            send_left_next    = (req == i2crte_pkg::REQ_START_WR) ? clamp_cnt : 8'd0;
            receive_left_next = (req == i2crte_pkg::REQ_START_WR) ? 8'd0 : count;
            phase_next        = i2crte_pkg::PH_SEND_REG;
          end
        end
        i2crte_pkg::REQ_TX_READY: begin
          if (role) begin
            byte_pointer_next = byte_pointer + 8'd1;
            send_left_next    = send_dec;
            if (send_dec == 8'd0) begin
              phase_next = i2crte_pkg::PH_SELECT;
            end
          end else if (phase == i2crte_pkg::PH_SEND_REG) begin
            phase_next = (receive_left != 8'd0) ? i2crte_pkg::PH_READ_START
                                                : i2crte_pkg::PH_TRANSMIT;
          end else if (phase == i2crte_pkg::PH_READ_START) begin
            phase_next = i2crte_pkg::PH_READ;
          end else if (phase == i2crte_pkg::PH_TRANSMIT) begin
            if (send_left != 8'd0) begin
              byte_pointer_next = byte_pointer + 8'd1;
              send_left_next    = send_dec;
            end else begin
              phase_next = i2crte_pkg::PH_IDLE;
            end
          end
        end
        i2crte_pkg::REQ_RX_BYTE: begin
          if (role) begin
            if (phase == i2crte_pkg::PH_DATA) begin
              byte_pointer_next = byte_pointer + 8'd1;
              receive_left_next = recv_dec;
              if (recv_dec == 8'd0) begin
                phase_next = i2crte_pkg::PH_SELECT;
              end
            end else begin
              selected_register_next = data_byte;
              byte_pointer_next      = sel_prod[7:0];
              receive_left_next      = reg_size;
              send_left_next         = reg_size;
              phase_next             = i2crte_pkg::PH_DATA;
            end
          end else if (phase == i2crte_pkg::PH_READ) begin
            if (receive_left != 8'd0) begin
              read_position_next = read_position + 8'd1;
            end
            receive_left_next = read_left;
            if (read_left == 8'd0) begin
              phase_next = i2crte_pkg::PH_IDLE;
            end
          end
        end
        i2crte_pkg::REQ_STOP, i2crte_pkg::REQ_HOST, i2crte_pkg::REQ_NONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  // result fields and memory request
  always_comb begin
    res         = '0;
    mem         = '0;
    mem.wr_data = data_byte;
    if (accept) begin
      unique case (req)
        i2crte_pkg::REQ_START_WR, i2crte_pkg::REQ_START_RD: begin
          if (!role) begin
            res.start_cond     = 1'b1;
            res.target_address = dev_addr;
          end
        end
        i2crte_pkg::REQ_TX_READY: begin
          if (role) begin
            res.tx_valid    = 1'b1;
            res.tx_from_mem = 1'b1;
            mem.rd_en       = 1'b1;
            mem.addr        = byte_pointer[i2crte_pkg::MEM_ADDR_W-1:0];
          end else if (phase == i2crte_pkg::PH_SEND_REG) begin
            res.tx_valid = 1'b1;
            res.tx_byte  = selected_register;
          end else if (phase == i2crte_pkg::PH_READ_START) begin
            res.start_cond     = 1'b1;
            res.read_dir       = 1'b1;
            res.target_address = peer_address;
            res.stop_cond      = (receive_left == 8'd1);
          end else if (phase == i2crte_pkg::PH_TRANSMIT) begin
            if (send_left != 8'd0) begin
              res.tx_valid = 1'b1;
              res.tx_byte  = tx_store[byte_pointer[i2crte_pkg::TX_IDX_W-1:0]];
            end else begin
              res.stop_cond = 1'b1;
              res.done_res  = 1'b1;
            end
          end
        end
        i2crte_pkg::REQ_RX_BYTE: begin
          if (role) begin
            if (phase == i2crte_pkg::PH_DATA) begin
              mem.wr_en = 1'b1;
              mem.addr  = byte_pointer[i2crte_pkg::MEM_ADDR_W-1:0];
            end
          end else if (phase == i2crte_pkg::PH_READ) begin
            if (receive_left != 8'd0) begin
              res.rx_valid = 1'b1;
              res.rx_byte  = data_byte;
              res.rx_index = read_position;
            end
            res.stop_cond = (read_left == 8'd1);
            res.done_res  = (read_left == 8'd0);
          end
        end
        i2crte_pkg::REQ_HOST: begin
          mem.addr = mem_index[i2crte_pkg::MEM_ADDR_W-1:0];
          if (host_write) begin
            mem.wr_en = 1'b1;
          end else begin
            mem.rd_en       = 1'b1;
            res.rx_from_mem = 1'b1;
          end
        end
        i2crte_pkg::REQ_LOAD, i2crte_pkg::REQ_STOP, i2crte_pkg::REQ_NONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= i2crte_pkg::PH_IDLE;
      role              <= 1'b0;
      reg_size          <= 8'd1;
      byte_pointer      <= 8'd0;
      send_left         <= 8'd0;
      receive_left      <= 8'd0;
      selected_register <= 8'd0;
      read_position     <= 8'd0;
      peer_address      <= 7'd0;
    end else begin
      phase             <= phase_next;
      role              <= role_next;
      reg_size          <= reg_size_next;
      byte_pointer      <= byte_pointer_next;
      send_left         <= send_left_next;
      receive_left      <= receive_left_next;
      selected_register <= selected_register_next;
      read_position     <= read_position_next;
      peer_address      <= peer_address_next;
    end
  end

  always_ff @(posedge clk) begin
    if (tx_we) begin
      tx_store[mem_index[i2crte_pkg::TX_IDX_W-1:0]] <= data_byte;
    end
  end

`ifndef ASSERT_OFF
  a_target_phase: assert property (@(posedge clk) disable iff (rst)
    role |-> (phase == i2crte_pkg::PH_SELECT || phase == i2crte_pkg::PH_DATA))
    else $error("target role outside select/data phase");

  a_master_phase: assert property (@(posedge clk) disable iff (rst)
    !role |-> (phase != i2crte_pkg::PH_SELECT && phase != i2crte_pkg::PH_DATA))
    else $error("master role in a target phase");

  a_mem_port: assert property (@(posedge clk) disable iff (rst)
    !(mem.rd_en && mem.wr_en))
    else $error("memory read and write requested by one item");
`endif

endmodule

[rtl/core/i2c_register_transfer_engine_unit.sv]
// Top level of the I2C register transfer engine.
// Instantiates the sequencer and the target register memory, and holds the result register.
// Depends on i2crte_pkg, i2crte_seq and i2crte_ram.
//
// Usage:
//   Input items arrive on in_valid/in_ready with one port per field; each item
//   yields exactly one result on out_valid/out_ready.
//   Configuration is written through cfg_we/cfg_index/cfg_data: index 0 role,
//   index 1 own address (held by the bus layer, not used here), index 2
//   register size. Write it only while no item is in flight.
//   out_valid rises in the cycle after acceptance; one item is taken per cycle
//   while out_ready is high. The result register and the target memory read port
//   set this: memory data is read at acceptance and merged at the output.
//   in_ready is high while the result register is empty or being drained, so
//   a stalled receiver holds the current result and blocks new items.
//   Reset selects master role, idle phase, register size 1, and clears the
//   per-entry valid bits so the target memory reads as zero; no clearing
//   pass is needed and items are accepted in the first cycle after reset.
`timescale 1ns / 1ps

module i2c_register_transfer_engine_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [i2crte_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [i2crte_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [2:0]                        req_type,
  input  logic [6:0]                        dev_addr,
  input  logic [7:0]                        reg_addr,
  input  logic [7:0]                        count,
  input  logic [7:0]                        data_byte,
  input  logic [7:0]                        mem_index,
  input  logic                              host_write,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              start_cond,
  output logic                              read_dir,
  output logic [6:0]                        target_address,
  output logic                              stop_cond,
  output logic                              tx_valid,
  output logic [7:0]                        tx_byte,
  output logic                              rx_valid,
  output logic [7:0]                        rx_byte,
  output logic [7:0]                        rx_index,
  output logic                              done_res
);

  logic                 accept;
  i2crte_pkg::res_t     res;
  i2crte_pkg::mem_req_t mem;
  i2crte_pkg::res_t     out_res;
  logic                 mem_hit;
  logic [7:0]           ram_q;
  logic [7:0]           mem_byte;
  logic [i2crte_pkg::TARGET_MEM_BYTES-1:0] mem_valid;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  i2crte_seq u_seq (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .accept           (accept),
    .req_type         (req_type),
    .dev_addr         (dev_addr),
    .reg_addr         (reg_addr),
    .count            (count),
    .data_byte        (data_byte),
    .mem_index        (mem_index),
    .host_write       (host_write),
    .res              (res),
    .mem              (mem)
  );

  i2crte_ram #(
    .WIDTH (8),
    .DEPTH (i2crte_pkg::TARGET_MEM_BYTES)
  ) u_mem (
    .clk   (clk),
    .we    (mem.wr_en),
    .waddr (mem.addr),
    .wdata (mem.wr_data),
    .re    (mem.rd_en),
    .raddr (mem.addr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_valid <= '0;
    end else if (mem.wr_en) begin
      mem_valid[mem.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_res <= res;
      mem_hit <= mem_valid[mem.addr];
    end
  end

  assign mem_byte       = mem_hit ? ram_q : 8'd0;
  assign start_cond     = out_res.start_cond;
  assign read_dir       = out_res.read_dir;
  assign target_address = out_res.target_address;
  assign stop_cond      = out_res.stop_cond;
  assign tx_valid       = out_res.tx_valid;
  assign tx_byte        = out_res.tx_from_mem ? mem_byte : out_res.tx_byte;
  assign rx_valid       = out_res.rx_valid;
  assign rx_byte        = out_res.rx_from_mem ? mem_byte : out_res.rx_byte;
  assign rx_index       = out_res.rx_index;
  assign done_res       = out_res.done_res;

`ifndef ASSERT_OFF
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted item left no result");

  a_start_alone: assert property (@(posedge clk) disable iff (rst)
    (out_valid && start_cond) |-> (!tx_valid && !rx_valid))
    else $error("start issued together with a data byte");

  a_single_dir: assert property (@(posedge clk) disable iff (rst)
    (out_valid && rx_valid) |-> (!tx_valid && !out_res.rx_from_mem))
    else $error("received byte collides with transmit or memory data");
`endif

endmodule

[tb/sv/i2crte_tb_pkg.sv]
// Item and result types plus the checker class for the I2C register transfer engine bench.
// The checker predicts each result from its own copy of the engine state.
// Depends on i2crte_pkg.
`timescale 1ns / 1ps

package i2crte_tb_pkg;
  import i2crte_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDR = 2'd1;

  typedef struct packed {
    req_e_t     req;
    logic [6:0] dev;
    logic [7:0] reg_num;
    logic [7:0] cnt;
    logic [7:0] data;
    logic [7:0] idx;
    logic       hw;
  } bus_item_t;

  typedef struct packed {
    logic       start_cond;
    logic       read_dir;
    logic [6:0] target_address;
    logic       stop_cond;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic [7:0] rx_index;
    logic       done_res;
  } bus_result_t;

  class bus_op_checker;
    bit          role;
    logic [6:0]  own_addr;
    logic [7:0]  reg_size;
    phase_t      ph;
    logic [7:0]  tx_store [TX_DEPTH];
    logic [7:0]  target_mem [TARGET_MEM_BYTES];
    logic [7:0]  ptr;
    logic [7:0]  send_left;
    logic [7:0]  recv_left;
    logic [7:0]  sel_reg;
    logic [7:0]  rd_pos;
    logic [6:0]  peer;
    bus_result_t expected_ops [$];
    int          errors;
    int          n_items;

    function new();
      role = 1'b0;
      own_addr = '0;
      reg_size = 8'd1;
      ph = PH_IDLE;
      foreach (tx_store[i]) tx_store[i] = '0;
      foreach (target_mem[i]) target_mem[i] = '0;
      ptr = '0;
      send_left = '0;
      recv_left = '0;
      sel_reg = '0;
      rd_pos = '0;
      peer = '0;
      errors = 0;
      n_items = 0;
    endfunction

    function int pending();
      return expected_ops.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
      case (index)
        CFG_ROLE: begin
          role = value[0];
          ph = role ? PH_SELECT : PH_IDLE;
        end
        CFG_OWN_ADDR: own_addr = value[6:0];
        CFG_REG_SIZE: reg_size = value[7:0];
        default: ;
      endcase
    endfunction

    function void note_item(bus_item_t it);
      bus_result_t r;
      logic [15:0] prod;
      r = '0;
      n_items++;
      case (it.req)
        REQ_LOAD: begin
          if (it.idx < TX_DEPTH) tx_store[int'(it.idx)] = it.data;
        end
        REQ_START_WR, REQ_START_RD: begin
          if (!role) begin
            peer = it.dev;
            sel_reg = it.reg_num;
            ptr = '0;
            rd_pos = '0;
            if (it.req == REQ_START_WR) begin
              send_left = (it.cnt > TX_DEPTH) ? 8'(TX_DEPTH) : it.cnt;
              recv_left = '0;
            end else begin
              send_left = '0;
              recv_left = it.cnt;
            end
            ph = PH_SEND_REG;
            r.start_cond = 1'b1;
            r.target_address = it.dev;
          end
        end
        REQ_TX_READY: begin
          if (role) begin
            r.tx_valid = 1'b1;
            r.tx_byte = target_mem[int'(ptr) % TARGET_MEM_BYTES];
            ptr++;
            send_left--;
            if (send_left == 0) ph = PH_SELECT;
          end else begin
            case (ph)
              PH_SEND_REG: begin
                r.tx_valid = 1'b1;
                r.tx_byte = sel_reg;
                ph = (recv_left != 0) ? PH_READ_START : PH_TRANSMIT;
              end
              PH_READ_START: begin
                ph = PH_READ;
                r.start_cond = 1'b1;
                r.read_dir = 1'b1;
                r.target_address = peer;
                r.stop_cond = (recv_left == 1);
              end
              PH_TRANSMIT: begin
                if (send_left != 0) begin
                  r.tx_valid = 1'b1;
                  r.tx_byte = tx_store[int'(ptr) % TX_DEPTH];
                  ptr++;
                  send_left--;
                end else begin
                  r.stop_cond = 1'b1;
                  r.done_res = 1'b1;
                  ph = PH_IDLE;
                end
              end
              default: ;
            endcase
          end
        end
        REQ_RX_BYTE: begin
          if (role) begin
            if (ph == PH_DATA) begin
              target_mem[int'(ptr) % TARGET_MEM_BYTES] = it.data;
              ptr++;
              recv_left--;
              if (recv_left == 0) ph = PH_SELECT;
            end else begin
              sel_reg = it.data;
              prod = reg_size * it.data;
              ptr = prod[7:0];
              recv_left = reg_size;
              send_left = reg_size;
              ph = PH_DATA;
            end
          end else if (ph == PH_READ) begin
            if (recv_left != 0) begin
              r.rx_valid = 1'b1;
              r.rx_byte = it.data;
              r.rx_index = rd_pos;
              rd_pos++;
              recv_left--;
            end
            if (recv_left == 1) begin
              r.stop_cond = 1'b1;
            end else if (recv_left == 0) begin
              r.done_res = 1'b1;
              ph = PH_IDLE;
            end
          end
        end
        REQ_HOST: begin
          if (it.hw) target_mem[int'(it.idx) % TARGET_MEM_BYTES] = it.data;
          else r.rx_byte = target_mem[int'(it.idx) % TARGET_MEM_BYTES];
        end
        default: ;
      endcase
      expected_ops.push_back(r);
    endfunction

    function void cmp(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(bus_result_t got);
      bus_result_t want;
      if (expected_ops.size() == 0) begin
        $error("result with nothing expected");
        errors++;
        return;
      end
      want = expected_ops.pop_front();
      cmp("start_cond", want.start_cond, got.start_cond);
      cmp("read_dir", want.read_dir, got.read_dir);
      cmp("target_address", want.target_address, got.target_address);
      cmp("stop_cond", want.stop_cond, got.stop_cond);
      cmp("tx_valid", want.tx_valid, got.tx_valid);
      cmp("tx_byte", want.tx_byte, got.tx_byte);
      cmp("rx_valid", want.rx_valid, got.rx_valid);
      cmp("rx_byte", want.rx_byte, got.rx_byte);
      cmp("rx_index", want.rx_index, got.rx_index);
      cmp("done_res", want.done_res, got.done_res);
    endfunction
  endclass

endpackage

[tb/sv/i2c_register_transfer_engine_unit_tb.sv]
// Bench for the I2C register transfer engine: directed and random master and target
// traffic with random stalls on both sides, checked item by item against bus_op_checker.
// Depends on i2crte_pkg, i2crte_tb_pkg and the engine RTL.
`timescale 1ns / 1ps

module i2c_register_transfer_engine_unit_tb;
  import i2crte_pkg::*;
  import i2crte_tb_pkg::*;

  localparam int STIM_ITEMS = 650;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [2:0]            req_type;
  logic [6:0]            dev_addr;
  logic [7:0]            reg_addr;
  logic [7:0]            count;
  logic [7:0]            data_byte;
  logic [7:0]            mem_index;
  logic                  host_write;
  logic                  out_valid;
  logic                  out_ready;
  logic                  start_cond;
  logic                  read_dir;
  logic [6:0]            target_address;
  logic                  stop_cond;
  logic                  tx_valid;
  logic [7:0]            tx_byte;
  logic                  rx_valid;
  logic [7:0]            rx_byte;
  logic [7:0]            rx_index;
  logic                  done_res;

  bus_op_checker sb;
  int            n_stim;
  bit            quiet;

  i2c_register_transfer_engine_unit u_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .req_type         (req_type),
    .dev_addr         (dev_addr),
    .reg_addr         (reg_addr),
    .count            (count),
    .data_byte        (data_byte),
    .mem_index        (mem_index),
    .host_write       (host_write),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .start_cond       (start_cond),
    .read_dir         (read_dir),
    .target_address   (target_address),
    .stop_cond        (stop_cond),
    .tx_valid         (tx_valid),
    .tx_byte          (tx_byte),
    .rx_valid         (rx_valid),
    .rx_byte          (rx_byte),
    .rx_index         (rx_index),
    .done_res         (done_res)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic bus_item_t any_item(req_e_t r);
    bus_item_t it;
    it.req = r;
    it.dev = 7'($urandom_range(0, 127));
    it.reg_num = 8'($urandom_range(0, 255));
    it.cnt = 8'($urandom_range(0, 255));
    it.data = 8'($urandom_range(0, 255));
    it.idx = 8'($urandom_range(0, 255));
    it.hw = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic bus_item_t item(req_e_t r, int dev, int reg_num, int cnt, int data,
                                     int idx, bit hw);
    bus_item_t it;
    it.req = r;
    it.dev = 7'(dev);
    it.reg_num = 8'(reg_num);
    it.cnt = 8'(cnt);
    it.data = 8'(data);
    it.idx = 8'(idx);
    it.hw = hw;
    return it;
  endfunction

  task automatic push(bus_item_t it, bit counted);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_type <= it.req;
    dev_addr <= it.dev;
    reg_addr <= it.reg_num;
    count <= it.cnt;
    data_byte <= it.data;
    mem_index <= it.idx;
    host_write <= it.hw;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(it);
    if (counted) n_stim++;
  endtask

  // drop valid and wait until every result is back
  task automatic drain();
    int waited;
    waited = 0;
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(index, value);
  endtask

  task automatic configure(bit role, int own, int size);
    drain();
    set_reg(CFG_ROLE, CFG_DATA_W'(role));
    set_reg(CFG_OWN_ADDR, CFG_DATA_W'(own));
    set_reg(CFG_REG_SIZE, CFG_DATA_W'(size));
  endtask

  task automatic master_write();
    bus_item_t it;
    int r;
    int n;
    int sends;
    repeat ($urandom_range(0, 3)) begin
      it = any_item(REQ_LOAD);
      it.idx = 8'($urandom_range(0, TX_DEPTH - 1));
      push(it, 1'b1);
    end
    r = $urandom_range(0, 99);
    n = (r < 80) ? $urandom_range(0, TX_DEPTH) : $urandom_range(TX_DEPTH + 1, 255);
    it = any_item(REQ_START_WR);
    it.cnt = 8'(n);
    push(it, 1'b1);
    sends = ((n > TX_DEPTH) ? TX_DEPTH : n) + 2;
    if ($urandom_range(0, 9) == 0) sends = $urandom_range(0, sends);
    repeat (sends) push(any_item(REQ_TX_READY), 1'b1);
  endtask

  task automatic master_read();
    bus_item_t it;
    int r;
    int n;
    int nrx;
    r = $urandom_range(0, 99);
    n = (r < 70) ? $urandom_range(1, 6) : (r < 85) ? 0 : $urandom_range(7, 40);
    it = any_item(REQ_START_RD);
    it.cnt = 8'(n);
    push(it, 1'b1);
    push(any_item(REQ_TX_READY), 1'b1);
    push(any_item(REQ_TX_READY), 1'b1);
    nrx = n;
    if (n > 0 && $urandom_range(0, 9) == 0) nrx = $urandom_range(0, n - 1);
    repeat (nrx) push(any_item(REQ_RX_BYTE), 1'b1);
  endtask

  task automatic target_access(bit is_write);
    int k;
    push(any_item(REQ_RX_BYTE), 1'b1);
    k = ($urandom_range(0, 1) && sb.reg_size <= 24) ? sb.reg_size : $urandom_range(0, 6);
    repeat (k) push(any_item(is_write ? REQ_RX_BYTE : REQ_TX_READY), 1'b1);
    push(any_item(REQ_STOP), 1'b1);
  endtask

  task automatic noise();
    repeat ($urandom_range(1, 3)) push(any_item(req_e_t'($urandom_range(0, 7))), 1'b0);
  endtask

  task automatic directed();
    for (int i = 0; i < TX_DEPTH; i++)
      push(item(REQ_LOAD, 0, 0, 0, (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : $urandom_range(0, 255),
                i, 1'b0), 1'b1);
    push(item(REQ_LOAD, 0, 0, 0, 8'h5A, TX_DEPTH, 1'b0), 1'b1);
    push(item(REQ_LOAD, 0, 0, 0, 8'hFF, 255, 1'b0), 1'b1);
    push(item(REQ_START_WR, 127, 255, 2, 0, 0, 1'b0), 1'b1);
    repeat (4) push(item(REQ_TX_READY, 0, 0, 0, 0, 0, 1'b0), 1'b1);
    push(item(REQ_START_RD, 0, 0, 1, 0, 0, 1'b0), 1'b1);
    repeat (2) push(item(REQ_TX_READY, 0, 0, 0, 0, 0, 1'b0), 1'b1);
    push(item(REQ_RX_BYTE, 0, 0, 0, 8'hFF, 0, 1'b0), 1'b1);
    push(item(REQ_START_RD, 85, 170, 0, 0, 0, 1'b0), 1'b1);
    repeat (2) push(item(REQ_TX_READY, 0, 0, 0, 0, 0, 1'b0), 1'b1);
    push(item(REQ_STOP, 0, 0, 0, 0, 0, 1'b0), 1'b1);
    push(item(REQ_NONE, 127, 255, 255, 255, 255, 1'b1), 1'b1);
    push(item(REQ_TX_READY, 0, 0, 0, 0, 0, 1'b0), 1'b1);
    push(item(REQ_RX_BYTE, 0, 0, 0, 8'h3C, 0, 1'b0), 1'b1);
    push(item(REQ_HOST, 0, 0, 0, 8'hFF, 255, 1'b1), 1'b1);
    push(item(REQ_HOST, 0, 0, 0, 0, 255, 1'b0), 1'b1);
    push(item(REQ_HOST, 0, 0, 0, 0, 0, 1'b0), 1'b1);
    configure(1'b1, 127, 255);
    push(item(REQ_RX_BYTE, 0, 0, 0, 1, 0, 1'b0), 1'b1);
    push(item(REQ_RX_BYTE, 0, 0, 0, 8'hA5, 0, 1'b0), 1'b1);
    push(item(REQ_RX_BYTE, 0, 0, 0, 8'h00, 0, 1'b0), 1'b1);
    push(item(REQ_TX_READY, 0, 0, 0, 0, 0, 1'b0), 1'b1);
    push(item(REQ_START_WR, 5, 6, 7, 0, 0, 1'b0), 1'b1);
    push(item(REQ_HOST, 0, 0, 0, 0, 255, 1'b0), 1'b1);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result({start_cond, read_dir, target_address, stop_cond, tx_valid, tx_byte,
                       rx_valid, rx_byte, rx_index, done_res});
  end

  initial begin
    bit held;
    int pick;
    int len;
    held = 1'b0;
    out_ready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (!held && sb.n_items >= 150) begin
        // hold off long enough for the engine to back up its input
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (300) @(negedge clk);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          out_ready <= 1'b1;
          len = $urandom_range(1, 20);
        end else begin
          out_ready <= 1'b0;
          len = (pick < 93) ? $urandom_range(1, 4) : $urandom_range(10, 40);
        end
        repeat (len) @(negedge clk);
      end
    end
  end

  initial begin
    int p;
    int goal;
    int r;
    int size;
    int own;
    sb = new();
    n_stim = 0;
    quiet = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    req_type = REQ_NONE;
    dev_addr = '0;
    reg_addr = '0;
    count = '0;
    data_byte = '0;
    mem_index = '0;
    host_write = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    directed();

    p = 0;
    while (n_stim < STIM_ITEMS) begin
      case (p)
        0, 1: size = 255;
        2, 3: size = 1;
        default: size = $urandom_range(0, 1) ? $urandom_range(1, 6) : $urandom_range(1, 255);
      endcase
      own = (p == 0) ? 127 : (p == 1) ? 0 : $urandom_range(0, 127);
      configure(1'(p % 2), own, size);
      goal = n_stim + 70;
      while (n_stim < goal) begin
        quiet = ($urandom_range(0, 7) == 0);
        r = $urandom_range(0, 99);
        if (r >= 85) noise();
        else if (r >= 75) push(any_item(REQ_HOST), 1'b1);
        else if (p % 2 == 0) begin
          if (r < 40) master_write();
          else master_read();
        end else begin
          target_access(r < 40);
        end
      end
      p++;
    end

    drain();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/i2crte_pkg.sv
rtl/core/i2crte_ram.sv
rtl/core/i2crte_seq.sv
rtl/core/i2c_register_transfer_engine_unit.sv
tb/sv/i2crte_tb_pkg.sv
tb/sv/i2c_register_transfer_engine_unit_tb.sv
